/* sv/ctfd_pkg.sv */
// ----------------------------------------------------------------------------
// ctfd_pkg
// Shared types and constants of the CAN telemetry frame decoder.
// ----------------------------------------------------------------------------
package ctfd_pkg;

   typedef enum logic [1:0] {
      ACT_FRAME    = 2'd0,
      ACT_TICK     = 2'd1,
      ACT_GEN_LOG  = 2'd2,
      ACT_TEMP_LOG = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_MOTOR1  = 3'd0,
      KIND_MOTOR2  = 3'd1,
      KIND_BMS     = 3'd2,
      KIND_DIFF    = 3'd3,
      KIND_TEMP    = 3'd4,
      KIND_IGNORED = 3'd5,
      KIND_STATUS  = 3'd6
   } kind_type;

   localparam logic [10:0] ID_TEMP_BASE = 11'h321;
   localparam logic [10:0] ID_MOTOR1    = 11'h331;
   localparam logic [10:0] ID_MOTOR2    = 11'h332;
   localparam logic [10:0] ID_BMS       = 11'h333;
   localparam logic [10:0] ID_DIFF      = 11'h334;

   localparam int AGE_W = 16;
   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   localparam int SRC_MOTOR1 = 0;
   localparam int SRC_MOTOR2 = 1;
   localparam int SRC_DIFF   = 2;
   localparam int SRC_BMS    = 3;
   localparam int SRC_TEMPS  = 4;
   localparam int SRC_COUNT  = 5;

   localparam int SEEN_MOTOR1 = 0;
   localparam int SEEN_MOTOR2 = 1;
   localparam int SEEN_BMS    = 2;

   localparam logic [15:0] VCU_TIMEOUT_RESET = 16'd300;
   localparam logic [15:0] BMS_TIMEOUT_RESET = 16'd1500;

   localparam logic CSR_VCU_TIMEOUT = 1'b0;
   localparam logic CSR_BMS_TIMEOUT = 1'b1;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;

   // packed from the top bit down; first_value lands in bits 15:0
   typedef struct packed {
      logic              bms_alive;
      logic              vcu_alive;
      logic              temps_ready;
      logic              general_ready;
      logic [7:0]        fifth_value;
      logic [7:0]        fourth_value;
      logic [9:0]        third_value;
      logic signed [8:0] main_temp;
      logic signed [8:0] controller_temp;
      logic [15:0]       second_value;
      logic [15:0]       first_value;
   } rsp_data_type;

   typedef struct packed {
      kind_type     kind;
      rsp_data_type data;
   } rsp_item_type;

   function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] age);
      age_step = (age == AGE_MAX) ? age : age + AGE_W'(1);
   endfunction

endpackage

/* sv/can_telemetry_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// can_telemetry_frame_decoder_top
// Decodes CAN telemetry frames, ages each source on millisecond ticks and
// reports arrival and liveness flags, one result beat per request beat.
// ----------------------------------------------------------------------------
// The frame decode, the age update and the timeout compares are one short
// combinational pass from the request port and state registers into the result
// or skid register, so a beat can be accepted on every clock while the skid
// register is empty. A two-entry output stage (result plus skid register) keeps
// the request side open for one beat while a result waits on rsp_tready. The user
// must write timeouts through the csr port only while the block is idle; not enforced.
module can_telemetry_frame_decoder_top
   import ctfd_pkg::*;
#(
   parameter int TEMP_PACKETS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // action
   input  logic [REQ_DATA_W-1:0] req_tdata,   // frame_id[10:0], frame_data[74:11], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2:0]            rsp_tuser,   // record_kind
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // first_value, second_value, controller_temp,
                                              // main_temp, third_value, fourth_value,
                                              // fifth_value, general_ready, temps_ready,
                                              // vcu_alive, bms_alive
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam int IDX_W = (TEMP_PACKETS > 1) ? $clog2(TEMP_PACKETS) : 1;
   localparam logic [TEMP_PACKETS-1:0] TEMPS_ALL = '1;

   logic [15:0]             vcu_timeout_ff;
   logic [15:0]             bms_timeout_ff;
   logic [AGE_W-1:0]        age_ff [SRC_COUNT];
   logic [AGE_W-1:0]        age_in [SRC_COUNT];
   logic [2:0]              seen_ff;
   logic [2:0]              seen_in;
   logic [TEMP_PACKETS-1:0] temps_ff;
   logic [TEMP_PACKETS-1:0] temps_in;

   rsp_item_type            out_ff;
   rsp_item_type            skid_ff;
   logic                    out_valid_ff;
   logic                    skid_valid_ff;
   rsp_item_type            result;

   action_type              action;
   logic [10:0]             frame_id;
   logic [63:0]             frame_data;
   logic [7:0]              b [8];
   logic [10:0]             id_off;
   logic                    is_temp;
   logic [17:0]             pwm_prod;
   logic [26:0]             pwm_scaled;
   logic [9:0]              pwm_est;
   logic [18:0]             pwm_rem;
   logic [9:0]              pwm_permille;
   logic                    req_fire;
   logic                    rsp_fire;

   assign action     = action_type'(req_tuser);
   assign frame_id   = req_tdata[10:0];
   assign frame_data = req_tdata[74:11];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         b[k] = frame_data[8*k +: 8];
      end
   end

   assign id_off  = frame_id - ID_TEMP_BASE;
   assign is_temp = (frame_id >= ID_TEMP_BASE) && (id_off < 11'(TEMP_PACKETS));

   // byte6 * 1000 / 255 by reciprocal 257/65536 and one correction step
   assign pwm_prod     = ({10'd0, b[6]} << 10) - ({10'd0, b[6]} << 4) - ({10'd0, b[6]} << 3);
   assign pwm_scaled   = {1'b0, pwm_prod, 8'd0} + {9'd0, pwm_prod};
   assign pwm_est      = pwm_scaled[25:16];
   assign pwm_rem      = {1'b0, pwm_prod} - {1'b0, pwm_est, 8'd0} + {9'd0, pwm_est};
   assign pwm_permille = (pwm_rem >= 19'd255) ? pwm_est + 10'd1 : pwm_est;

   always_comb begin
      for (int s = 0; s < SRC_COUNT; s++) begin
         age_in[s] = age_ff[s];
      end
      seen_in     = seen_ff;
      temps_in    = temps_ff;
      result      = '0;
      result.kind = KIND_STATUS;
      case (action)
         ACT_FRAME: begin
            if (frame_id == ID_MOTOR1 || frame_id == ID_MOTOR2) begin
               result.data.first_value     = {4'd0, b[0][7:4], b[1]};
               result.data.second_value    = {b[5], b[4]};
               result.data.controller_temp = {1'b0, b[2]} - 9'sd100;
               result.data.main_temp       = {1'b0, b[3]} - 9'sd100;
               result.data.third_value     = pwm_permille;
               result.data.fourth_value    = b[7];
               if (frame_id == ID_MOTOR1) begin
                  result.kind             = KIND_MOTOR1;
                  age_in[SRC_MOTOR1]      = '0;
                  seen_in[SEEN_MOTOR1]    = 1'b1;
               end else begin
                  result.kind             = KIND_MOTOR2;
                  age_in[SRC_MOTOR2]      = '0;
                  seen_in[SEEN_MOTOR2]    = 1'b1;
               end
            end else if (frame_id == ID_BMS) begin
               result.kind              = KIND_BMS;
               result.data.first_value  = {9'd0, b[0][7:1]};
               result.data.second_value = {b[5], b[6]};
               result.data.main_temp    = {1'b0, b[4]};
               age_in[SRC_BMS]          = '0;
               seen_in[SEEN_BMS]        = 1'b1;
            end else if (frame_id == ID_DIFF) begin
               result.kind              = KIND_DIFF;
               result.data.first_value  = {8'd0, b[0]};
               result.data.second_value = {8'd0, b[1]};
               result.data.third_value  = {2'd0, b[2]};
               result.data.fourth_value = b[3];
               result.data.fifth_value  = b[4];
               age_in[SRC_DIFF]         = '0;
            end else if (is_temp) begin
               result.kind                   = KIND_TEMP;
               result.data.first_value       = {5'd0, id_off};
               temps_in[id_off[IDX_W-1:0]]   = 1'b1;
               age_in[SRC_TEMPS]             = '0;
            end else begin
               result.kind = KIND_IGNORED;
            end
         end
         ACT_TICK: begin
            for (int s = 0; s < SRC_COUNT; s++) begin
               age_in[s] = age_step(age_ff[s]);
            end
         end
         ACT_GEN_LOG: begin
            if (&seen_ff) begin
               seen_in = '0;
            end
         end
         ACT_TEMP_LOG: begin
            if (temps_ff == TEMPS_ALL) begin
               temps_in = '0;
            end
         end
         default: begin
         end
      endcase
      result.data.general_ready = &seen_in;
      result.data.temps_ready   = (temps_in == TEMPS_ALL);
      result.data.vcu_alive     = (age_in[SRC_MOTOR1] <= vcu_timeout_ff)
                               && (age_in[SRC_MOTOR2] <= vcu_timeout_ff)
                               && (age_in[SRC_DIFF] <= vcu_timeout_ff);
      result.data.bms_alive     = (age_in[SRC_BMS] <= bms_timeout_ff)
                               && (age_in[SRC_TEMPS] <= bms_timeout_ff);
   end

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = out_ff.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcu_timeout_ff <= VCU_TIMEOUT_RESET;
         bms_timeout_ff <= BMS_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VCU_TIMEOUT: vcu_timeout_ff <= csr_wdata;
            CSR_BMS_TIMEOUT: bms_timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SRC_COUNT; s++) begin
            age_ff[s] <= '0;
         end
         seen_ff  <= '0;
         temps_ff <= '0;
      end else if (req_fire) begin
         for (int s = 0; s < SRC_COUNT; s++) begin
            age_ff[s] <= age_in[s];
         end
         seen_ff  <= seen_in;
         temps_ff <= temps_in;
      end
   end

   // hold the result while stalled, park one more beat in the skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_fire) begin
            out_ff <= result;
         end
      end else if (req_fire) begin
         skid_ff <= result;
      end
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while the result register is empty");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !out_valid_ff) |=> out_valid_ff)
      else $error("accepted beat did not reach the result register");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.kind == KIND_STATUS || out_ff.kind == KIND_IGNORED))
         |-> (rsp_tdata[75:0] == '0))
      else $error("status or ignored result carries nonzero values");

   a_skid_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && req_fire) |=> skid_valid_ff)
      else $error("beat accepted under stall was not parked");

endmodule

/* bench/tb_can_telemetry_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// tb_can_telemetry_frame_decoder_top
// Drives CAN frames, millisecond ticks and logging acknowledgements into the
// frame decoder and checks every result beat against a cycle-free decoder
// model kept in the bench: decoded values, arrival flags and alive flags.
// Directed frames and timeout edges come first, then random traffic over
// several timeout settings, then a short tick run under the widest timeouts.
// ----------------------------------------------------------------------------
module tb_can_telemetry_frame_decoder_top
   import ctfd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEMP_COUNT  = 10;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;   // action
   logic [REQ_DATA_W-1:0] req_tdata;   // frame_id[10:0], frame_data[74:11], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [2:0]            rsp_tuser;   // record_kind
   logic [RSP_DATA_W-1:0] rsp_tdata;   // first_value, second_value, controller_temp,
                                       // main_temp, third_value, fourth_value,
                                       // fifth_value, general_ready, temps_ready,
                                       // vcu_alive, bms_alive
   logic                  csr_we;
   logic                  csr_index;
   logic [15:0]           csr_wdata;

   // decoder state as the bench sees it
   logic [15:0]           src_age [SRC_COUNT];
   logic [2:0]            seen_mask;
   logic [TEMP_COUNT-1:0] temp_map;
   logic [15:0]           vcu_limit;
   logic [15:0]           bms_limit;

   rsp_item_type          record_q [$];
   int                    error_count = 0;
   int unsigned           cycle_count = 0;
   int                    stall_left = 0;
   bit                    req_quiet = 1'b0;
   bit                    rsp_quiet = 1'b0;

   can_telemetry_frame_decoder_top #(
      .TEMP_PACKETS (TEMP_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_can_telemetry_frame_decoder_top failed");
         $finish;
      end
   end

   function automatic rsp_item_type decode_record(action_type act, logic [10:0] id,
                                                  logic [63:0] data);
      rsp_item_type rec;
      logic [7:0]   b [8];
      int           idx;
      for (int k = 0; k < 8; k++) b[k] = data[8*k +: 8];
      rec = '0;
      rec.kind = KIND_STATUS;
      case (act)
         ACT_FRAME: begin
            if (id == ID_MOTOR1 || id == ID_MOTOR2) begin
               rec.kind = (id == ID_MOTOR1) ? KIND_MOTOR1 : KIND_MOTOR2;
               rec.data.first_value     = {4'd0, b[0][7:4], b[1]};
               rec.data.second_value    = {b[5], b[4]};
               rec.data.controller_temp = {1'b0, b[2]} - 9'd100;
               rec.data.main_temp       = {1'b0, b[3]} - 9'd100;
               rec.data.third_value     = 10'((int'(b[6]) * 1000) / 255);
               rec.data.fourth_value    = b[7];
               if (id == ID_MOTOR1) begin
                  src_age[SRC_MOTOR1]    = '0;
                  seen_mask[SEEN_MOTOR1] = 1'b1;
               end else begin
                  src_age[SRC_MOTOR2]    = '0;
                  seen_mask[SEEN_MOTOR2] = 1'b1;
               end
            end else if (id == ID_BMS) begin
               rec.kind = KIND_BMS;
               rec.data.first_value  = {9'd0, b[0][7:1]};
               rec.data.second_value = {b[5], b[6]};
               rec.data.main_temp    = {1'b0, b[4]};
               src_age[SRC_BMS]      = '0;
               seen_mask[SEEN_BMS]   = 1'b1;
            end else if (id == ID_DIFF) begin
               rec.kind = KIND_DIFF;
               rec.data.first_value  = {8'd0, b[0]};
               rec.data.second_value = {8'd0, b[1]};
               rec.data.third_value  = {2'd0, b[2]};
               rec.data.fourth_value = b[3];
               rec.data.fifth_value  = b[4];
               src_age[SRC_DIFF]     = '0;
            end else if (id >= ID_TEMP_BASE && id < ID_TEMP_BASE + TEMP_COUNT) begin
               idx = int'(id - ID_TEMP_BASE);
               rec.kind = KIND_TEMP;
               rec.data.first_value = 16'(idx);
               temp_map[idx]        = 1'b1;
               src_age[SRC_TEMPS]   = '0;
            end else begin
               rec.kind = KIND_IGNORED;
            end
         end
         ACT_TICK: begin
            for (int s = 0; s < SRC_COUNT; s++)
               if (src_age[s] != 16'hFFFF) src_age[s] = src_age[s] + 16'd1;
         end
         ACT_GEN_LOG: begin
            if (&seen_mask) seen_mask = '0;
         end
         default: begin
            if (&temp_map) temp_map = '0;
         end
      endcase
      rec.data.general_ready = &seen_mask;
      rec.data.temps_ready   = &temp_map;
      rec.data.vcu_alive     = src_age[SRC_MOTOR1] <= vcu_limit &&
                               src_age[SRC_MOTOR2] <= vcu_limit &&
                               src_age[SRC_DIFF] <= vcu_limit;
      rec.data.bms_alive     = src_age[SRC_BMS] <= bms_limit &&
                               src_age[SRC_TEMPS] <= bms_limit;
      return rec;
   endfunction

   function automatic int gap_cycles(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] any_payload();
      return {$urandom(), $urandom()};
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // result side: random back-pressure, then compare each beat in order
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!rsp_quiet && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (record_q.size() == 0) begin
            $error("result beat with no record pending, kind %0d", rsp_tuser);
            error_count++;
         end else begin
            want = record_q.pop_front();
            check_field("record_kind", want.kind, rsp_tuser);
            check_field("first_value", want.data.first_value, got.first_value);
            check_field("second_value", want.data.second_value, got.second_value);
            check_field("controller_temp", want.data.controller_temp,
                        got.controller_temp);
            check_field("main_temp", want.data.main_temp, got.main_temp);
            check_field("third_value", want.data.third_value, got.third_value);
            check_field("fourth_value", want.data.fourth_value, got.fourth_value);
            check_field("fifth_value", want.data.fifth_value, got.fifth_value);
            check_field("general_ready", want.data.general_ready, got.general_ready);
            check_field("temps_ready", want.data.temps_ready, got.temps_ready);
            check_field("vcu_alive", want.data.vcu_alive, got.vcu_alive);
            check_field("bms_alive", want.data.bms_alive, got.bms_alive);
         end
      end
   end

   task automatic send_item(action_type act, logic [10:0] id, logic [63:0] data);
      int gap;
      gap = gap_cycles(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'd0, data, id};
      do @(posedge clock); while (!req_tready);
      record_q.push_back(decode_record(act, id, data));
   endtask

   task automatic send_frame(logic [10:0] id);
      send_item(ACT_FRAME, id, any_payload());
   endtask

   task automatic send_status(action_type act);
      send_item(act, 11'($urandom()), any_payload());
   endtask

   // drop valid, drain every pending result, let the pipeline settle
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (record_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leave the write enable high; the caller drops it after the last write
   task automatic write_csr(logic idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_VCU_TIMEOUT) vcu_limit = value;
      else bms_limit = value;
   endtask

   task automatic set_timeouts(logic [15:0] vcu, logic [15:0] bms);
      quiesce();
      write_csr(CSR_VCU_TIMEOUT, vcu);
      write_csr(CSR_BMS_TIMEOUT, bms);
      csr_we <= 1'b0;
   endtask

   task automatic refresh_sources();
      send_frame(ID_MOTOR1);
      send_frame(ID_MOTOR2);
      send_frame(ID_DIFF);
      send_frame(ID_BMS);
      send_frame(ID_TEMP_BASE + 11'($urandom_range(0, TEMP_COUNT - 1)));
   endtask

   task automatic test_directed_frames();
      send_item(ACT_FRAME, ID_MOTOR1, 64'h0);
      send_item(ACT_FRAME, ID_MOTOR1, '1);
      send_frame(ID_MOTOR2);
      send_status(ACT_GEN_LOG);
      send_item(ACT_FRAME, ID_BMS, '1);
      send_item(ACT_FRAME, ID_BMS, 64'h0);
      send_status(ACT_GEN_LOG);
      send_status(ACT_GEN_LOG);
      send_item(ACT_FRAME, ID_DIFF, '1);
      send_item(ACT_FRAME, ID_DIFF, 64'h0);
      send_frame(11'h000);
      send_frame(11'h7FF);
      send_frame(ID_TEMP_BASE - 11'd1);
      send_frame(ID_TEMP_BASE + 11'(TEMP_COUNT));
      send_frame(ID_DIFF + 11'd1);
      send_status(ACT_TEMP_LOG);
      for (int k = 0; k < TEMP_COUNT; k++) send_frame(ID_TEMP_BASE + 11'(k));
      send_status(ACT_TEMP_LOG);
      send_item(ACT_TICK, ID_MOTOR1, any_payload());
   endtask

   task automatic test_timeout_edges();
      set_timeouts(16'd0, 16'd0);
      send_status(ACT_TICK);
      refresh_sources();
      send_status(ACT_TICK);
      set_timeouts(16'd2, 16'd3);
      refresh_sources();
      repeat (5) send_status(ACT_TICK);
      send_frame(ID_MOTOR1);
      send_frame(ID_BMS);
      refresh_sources();
      repeat (4) send_status(ACT_TICK);
   endtask

   task automatic random_item();
      int r;
      int start;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         start = $urandom_range(0, TEMP_COUNT - 1);
         for (int k = 0; k < TEMP_COUNT; k++)
            send_frame(ID_TEMP_BASE + 11'((start + k) % TEMP_COUNT));
         send_status(ACT_TEMP_LOG);
      end else if (r < 10) begin
         send_frame(ID_BMS);
         send_frame(ID_MOTOR2);
         send_frame(ID_MOTOR1);
         send_status(ACT_GEN_LOG);
      end else if (r < 45) begin
         send_status(ACT_TICK);
      end else if (r < 75) begin
         case ($urandom_range(0, 4))
            0: send_frame(ID_MOTOR1);
            1: send_frame(ID_MOTOR2);
            2: send_frame(ID_BMS);
            3: send_frame(ID_DIFF);
            default: send_frame(ID_TEMP_BASE + 11'($urandom_range(0, TEMP_COUNT - 1)));
         endcase
      end else if (r < 82) begin
         send_frame(11'($urandom()));
      end else if (r < 91) begin
         send_status(ACT_GEN_LOG);
      end else begin
         send_status(ACT_TEMP_LOG);
      end
   endtask

   task automatic test_random_traffic();
      logic [15:0] vcu_set [4];
      logic [15:0] bms_set [4];
      vcu_set = '{16'd1, 16'($urandom_range(2, 30)), 16'hFFFF, 16'($urandom())};
      bms_set = '{16'd1, 16'($urandom_range(2, 30)), 16'd5, 16'($urandom_range(8, 40))};
      for (int p = 0; p < 4; p++) begin
         set_timeouts(vcu_set[p], bms_set[p]);
         for (int n = 0; n < 80; n++) begin
            if (n % 40 == 0) begin
               req_quiet = ($urandom_range(0, 3) == 0);
               rsp_quiet = ($urandom_range(0, 3) == 0);
            end
            random_item();
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   task automatic test_wide_timeouts();
      set_timeouts(16'hFFFF, 16'hFFFE);
      refresh_sources();
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      repeat (12) send_status(ACT_TICK);
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      set_timeouts(16'hFFFE, 16'hFFFF);
      repeat (3) send_status(ACT_TICK);
      send_frame(ID_MOTOR1);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = '0;
      for (int s = 0; s < SRC_COUNT; s++) src_age[s] = '0;
      seen_mask = '0;
      temp_map  = '0;
      vcu_limit = VCU_TIMEOUT_RESET;
      bms_limit = BMS_TIMEOUT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_timeout_edges();
      test_random_traffic();
      test_wide_timeouts();

      quiesce();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_can_telemetry_frame_decoder_top passed");
      end else begin
         $display("tb_can_telemetry_frame_decoder_top failed");
      end
      $finish;
   end

endmodule
